>>> design/szo_pkg.sv
// Shared types and constants of the swept box zone occupancy block.
`default_nettype none
package szo_pkg;

    localparam int COORD_W     = 24;  // Q15.8 coordinates
    localparam int DIM_W       = 23;  // zone extents
    localparam int OFF_W       = 25;  // entry offsets
    localparam int WORK_W      = 27;  // signed width of slab arithmetic
    localparam int ID_W        = 32;
    localparam int KIND_W      = 2;
    localparam int TIME_W      = 40;
    localparam int MODE_W      = 5;
    localparam int PERIOD_W    = 24;
    localparam int MAX_RESULTS = 16;

    // mode_flags bit positions
    localparam int MODE_NPC    = 0;
    localparam int MODE_PLAYER = 1;
    localparam int MODE_MOVER  = 2;
    localparam int MODE_JUMP   = 3;
    localparam int MODE_MULTI  = 4;

    // object kinds
    localparam logic [KIND_W-1:0] KIND_NPC    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PLAYER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MOVER  = 2'd3;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // register indexes
    localparam logic [2:0] REG_CENTER_X     = 3'd0;
    localparam logic [2:0] REG_BASE_Y       = 3'd1;
    localparam logic [2:0] REG_CENTER_Z     = 3'd2;
    localparam logic [2:0] REG_HALF_WIDTH_X = 3'd3;
    localparam logic [2:0] REG_HEIGHT_Y     = 3'd4;
    localparam logic [2:0] REG_HALF_DEPTH_Z = 3'd5;
    localparam logic [2:0] REG_MODE_FLAGS   = 3'd6;
    localparam logic [2:0] REG_STAY_PERIOD  = 3'd7;

    typedef enum logic [1:0] {
        OP_MOVE  = 2'd0,
        OP_LEAVE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EV_ENTERED = 2'd0,
        EV_LEFT    = 2'd1,
        EV_STAY    = 2'd2,
        EV_FULL    = 2'd3
    } evt_kind_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] center;  // x, floor y, z
        logic [2:0][DIM_W-1:0]   ext;     // half x, height y, half z
        logic [MODE_W-1:0]       mode;
        logic [PERIOD_W-1:0]     period;
    } cfg_t;

    typedef struct packed {
        op_t                     op;
        logic [KIND_W-1:0]       kind;
        logic [ID_W-1:0]         id;
        logic [2:0][COORD_W-1:0] seg_start;
        logic [2:0][COORD_W-1:0] seg_end;
        logic                    jumping;
        logic [TIME_W-1:0]       now_ms;
    } cmd_t;

    typedef struct packed {
        evt_kind_t             ev;
        logic [KIND_W-1:0]     okind;
        logic [ID_W-1:0]       id;
        logic [2:0][OFF_W-1:0] off;
        logic                  last;
    } evt_t;

endpackage
`default_nettype wire

>>> design/szo_queue.sv
// Two-entry queue that decouples producer and consumer.
`default_nettype none
module szo_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             in_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             out_valid
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign dout      = mem_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

>>> design/szo_front.sv
// Front end: unpacks input transfers, drops filtered and unknown items.
`default_nettype none
module szo_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [223:0]       s_tdata,
    input  logic [1:0]         s_tuser,
    input  szo_pkg::cfg_t      cfg,
    input  logic               q_ready,
    output logic               q_push,
    output szo_pkg::cmd_t      q_data
);
    import szo_pkg::*;

    logic filtered;
    logic keep;

    // field unpack
    always_comb
    begin
        q_data.op           = op_t'(s_tuser);
        q_data.kind         = s_tdata[1:0];
        q_data.id           = s_tdata[33:2];
        q_data.seg_start[0] = s_tdata[57:34];
        q_data.seg_start[1] = s_tdata[81:58];
        q_data.seg_start[2] = s_tdata[105:82];
        q_data.seg_end[0]   = s_tdata[129:106];
        q_data.seg_end[1]   = s_tdata[153:130];
        q_data.seg_end[2]   = s_tdata[177:154];
        q_data.jumping      = s_tdata[178];
        q_data.now_ms       = s_tdata[218:179];
    end

    // kind filter applies to moves only
    always_comb
    begin
        filtered = ((q_data.kind == KIND_NPC)    && !cfg.mode[MODE_NPC])
                || ((q_data.kind == KIND_PLAYER) && !cfg.mode[MODE_PLAYER])
                || ((q_data.kind == KIND_MOVER)  && !cfg.mode[MODE_MOVER]);
        unique case (q_data.op)
            OP_MOVE:  keep = !filtered;
            OP_LEAVE: keep = 1'b1;
            OP_TICK:  keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && keep;

endmodule
`default_nettype wire

>>> design/szo_back.sv
// Back end: table walk, slab sweep with serial divider, event generation.
`default_nettype none
module szo_back #(
    parameter int TABLE_DEPTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  szo_pkg::cfg_t  cfg,
    input  logic           cmd_valid,
    input  szo_pkg::cmd_t  cmd_data,
    output logic           cmd_pop,
    input  logic           evt_ready,
    output logic           evt_push,
    output szo_pkg::evt_t  evt_data
);
    import szo_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int FRAC_W  = FRACTION_BITS + 1;
    localparam int STEP_W  = $clog2(FRACTION_BITS);
    localparam int MAG_W   = WORK_W - 1;
    localparam int PROD_W  = MAG_W + FRAC_W;
    localparam int NEMIT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [FRAC_W-1:0] ONE      = FRAC_W'(1) << FRACTION_BITS;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRACTION_BITS - 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SEARCH = 10'b0000000010,
        ST_AXIS   = 10'b0000000100,
        ST_DIV    = 10'b0000001000,
        ST_MERGE  = 10'b0000010000,
        ST_LERP   = 10'b0000100000,
        ST_POST   = 10'b0001000000,
        ST_LEFT   = 10'b0010000000,
        ST_TICK   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    // occupancy table
    logic [TABLE_DEPTH-1:0] slot_valid_reg;
    logic [KIND_W-1:0]      slot_kind_reg [TABLE_DEPTH];
    logic [ID_W-1:0]        slot_id_reg   [TABLE_DEPTH];
    logic [TIME_W-1:0]      slot_time_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]       count_reg, count_next;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       found_idx_reg, found_idx_next;
    logic                   free_reg, free_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   left_has_reg, left_has_next;
    logic [IDX_W-1:0]       left_idx_reg, left_idx_next;
    logic                   hit_reg, hit_next;
    logic [1:0]             axis_reg, axis_next;
    logic                   ph_reg, ph_next;
    logic [FRAC_W-1:0]      fst_reg, fst_next;
    logic [FRAC_W-1:0]      fet_reg, fet_next;
    logic [FRAC_W-1:0]      val_reg, val_next;
    logic [FRAC_W-1:0]      q_reg, q_next;
    logic [WORK_W-1:0]      rem_reg, rem_next;
    logic [WORK_W-1:0]      den_reg, den_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    logic [2:0][OFF_W-1:0]  off_reg, off_next;
    logic [NEMIT_W-1:0]     nemit_reg, nemit_next;
    evt_t                   pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;

    // table write controls
    logic                   ins_en, clr_en, tim_en;

    // per-axis slab terms
    logic signed [WORK_W-1:0] s_w, e_w, c_w, ext_w, bmin_w, bmax_w, d_w;
    logic signed [WORK_W-1:0] num_w, den_w, hit_w, off_w;
    logic                     going_up, reject, need_div;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-FRACTION_BITS-1:0] part;
    logic                     in_end;

    // divider step
    logic [WORK_W-1:0]        trial;
    logic                     trial_ge;
    logic [FRAC_W-1:0]        q_shift;

    // slot under the walk index
    logic                     slot_match, slot_stay;
    logic [TIME_W-1:0]        age;
    logic                     multi, can_emit;

    assign s_w    = WORK_W'($signed(cmd_reg.seg_start[axis_reg]));
    assign e_w    = WORK_W'($signed(cmd_reg.seg_end[axis_reg]));
    assign c_w    = WORK_W'($signed(cfg.center[axis_reg]));
    assign ext_w  = WORK_W'(cfg.ext[axis_reg]);
    assign bmin_w = (axis_reg == AXIS_Y) ? c_w : c_w - ext_w;
    assign bmax_w = c_w + ext_w;
    assign d_w    = e_w - s_w;

    // slab reject test and division operands for the current phase
    always_comb
    begin
        going_up = (s_w < e_w);
        if (going_up)
        begin
            reject = (s_w > bmax_w) || (e_w < bmin_w);
            den_w  = e_w - s_w;
            if (!ph_reg)
            begin
                need_div = (s_w < bmin_w);
                num_w    = bmin_w - s_w;
            end
            else
            begin
                need_div = (e_w > bmax_w);
                num_w    = bmax_w - s_w;
            end
        end
        else
        begin
            reject = (e_w > bmax_w) || (s_w < bmin_w);
            den_w  = s_w - e_w;
            if (!ph_reg)
            begin
                need_div = (s_w > bmax_w);
                num_w    = s_w - bmax_w;
            end
            else
            begin
                need_div = (e_w < bmin_w);
                num_w    = s_w - bmin_w;
            end
        end
    end

    // interpolation of the entry point
    assign mag   = (d_w < 0) ? MAG_W'(-d_w) : MAG_W'(d_w);
    assign part  = prod_reg[PROD_W-1:FRACTION_BITS];
    assign hit_w = neg_reg ? s_w - WORK_W'(part) : s_w + WORK_W'(part);
    assign off_w = hit_w - c_w;

    // end point inside the half-open box
    always_comb
    begin
        logic signed [WORK_W-1:0] ee, cc, xx, lo, hi;
        in_end = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            ee = WORK_W'($signed(cmd_reg.seg_end[a]));
            cc = WORK_W'($signed(cfg.center[a]));
            xx = WORK_W'(cfg.ext[a]);
            lo = (a == 1) ? cc : cc - xx;
            hi = cc + xx;
            if (!(ee >= lo && ee < hi))
            begin
                in_end = 1'b0;
            end
        end
    end

    assign trial    = {rem_reg[WORK_W-2:0], 1'b0};
    assign trial_ge = (trial >= den_reg);
    assign q_shift  = {q_reg[FRAC_W-2:0], trial_ge};

    assign slot_match = slot_valid_reg[idx_reg] && (slot_kind_reg[idx_reg] == cmd_reg.kind)
                     && (slot_id_reg[idx_reg] == cmd_reg.id);
    assign age        = cmd_reg.now_ms - slot_time_reg[idx_reg];
    assign slot_stay  = slot_valid_reg[idx_reg] && (cmd_reg.now_ms >= slot_time_reg[idx_reg])
                     && (age >= TIME_W'(cfg.period))
                     && (nemit_reg < NEMIT_W'(MAX_RESULTS));
    assign multi      = cfg.mode[MODE_MULTI];
    assign can_emit   = !pend_valid_reg || evt_ready;

    // sequencer
    always_comb
    begin
        logic             f_found;
        logic [IDX_W-1:0] f_idx;
        logic [FRAC_W-1:0] fet_n;
        logic [CNT_W-1:0] cnt_dec;
        logic             emit_go;
        logic             emit_need;
        evt_t             emit_evt;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        left_has_next   = left_has_reg;
        left_idx_next   = left_idx_reg;
        hit_next        = hit_reg;
        axis_next       = axis_reg;
        ph_next         = ph_reg;
        fst_next        = fst_reg;
        fet_next        = fet_reg;
        val_next        = val_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        step_next       = step_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        off_next        = off_reg;
        nemit_next      = nemit_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cmd_pop         = 1'b0;
        evt_push        = 1'b0;
        evt_data        = pend_reg;
        ins_en          = 1'b0;
        clr_en          = 1'b0;
        tim_en          = 1'b0;
        emit_go         = 1'b0;
        emit_need       = 1'b0;
        emit_evt        = '0;
        emit_evt.okind  = cmd_reg.kind;
        emit_evt.id     = cmd_reg.id;
        f_found         = found_reg || slot_match;
        f_idx           = found_reg ? found_idx_reg : idx_reg;
        fet_n           = (val_reg < fet_reg) ? val_reg : fet_reg;
        cnt_dec         = (left_has_reg && count_reg != '0) ? count_reg - 1'b1 : count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_data;
                    idx_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    nemit_next = '0;
                    if (cmd_data.op == OP_TICK)
                    begin
                        state_next = (cfg.period == '0) ? ST_DONE : ST_TICK;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (slot_match && !found_reg)
                begin
                    found_next     = 1'b1;
                    found_idx_next = idx_reg;
                end
                if (!slot_valid_reg[idx_reg] && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next      = '0;
                    left_has_next = f_found;
                    left_idx_next = f_idx;
                    if (cmd_reg.op == OP_LEAVE)
                    begin
                        state_next = f_found ? ST_LEFT : ST_DONE;
                    end
                    else if (cfg.mode[MODE_JUMP] || !cmd_reg.jumping)
                    begin
                        axis_next  = AXIS_X;
                        ph_next    = 1'b0;
                        fst_next   = '0;
                        fet_next   = ONE;
                        state_next = ST_AXIS;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_POST;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_AXIS:
            begin
                if (reject)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_POST;
                end
                else if (need_div)
                begin
                    // first quotient bit straight from the operands
                    den_next   = den_w;
                    if (num_w >= den_w)
                    begin
                        rem_next = num_w - den_w;
                        q_next   = FRAC_W'(1);
                    end
                    else
                    begin
                        rem_next = num_w;
                        q_next   = '0;
                    end
                    step_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    val_next   = ph_reg ? ONE : '0;
                    state_next = ST_MERGE;
                end
            end

            ST_DIV:
            begin
                rem_next  = trial_ge ? trial - den_reg : trial;
                q_next    = q_shift;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    val_next   = (q_shift > ONE) ? ONE : q_shift;
                    state_next = ST_MERGE;
                end
            end

            ST_MERGE:
            begin
                if (!ph_reg)
                begin
                    fst_next   = (val_reg > fst_reg) ? val_reg : fst_reg;
                    ph_next    = 1'b1;
                    state_next = ST_AXIS;
                end
                else
                begin
                    fet_next = fet_n;
                    ph_next  = 1'b0;
                    if (fet_n < fst_reg)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_POST;
                    end
                    else if (axis_reg == AXIS_Z)
                    begin
                        axis_next  = AXIS_X;
                        state_next = ST_LERP;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_AXIS;
                    end
                end
            end

            ST_LERP:
            begin
                if (!ph_reg)
                begin
                    prod_next = PROD_W'(mag) * PROD_W'(fst_reg);
                    neg_next  = (d_w < 0);
                    ph_next   = 1'b1;
                end
                else
                begin
                    off_next[axis_reg] = off_w[OFF_W-1:0];
                    ph_next            = 1'b0;
                    if (axis_reg == AXIS_Z)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_POST;
                    end
                    else
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end

            ST_POST:
            begin
                emit_evt.off = off_reg;
                if (hit_reg && !found_reg)
                begin
                    if (free_reg)
                    begin
                        emit_need   = multi || (count_reg == '0);
                        emit_evt.ev = EV_ENTERED;
                    end
                    else
                    begin
                        emit_need   = 1'b1;
                        emit_evt.ev = EV_FULL;
                    end
                end
                if (!(emit_need && !can_emit))
                begin
                    emit_go = emit_need;
                    if (hit_reg && !found_reg)
                    begin
                        ins_en        = free_reg;
                        count_next    = free_reg ? count_reg + 1'b1 : count_reg;
                        left_has_next = free_reg;
                        left_idx_next = free_idx_reg;
                    end
                    state_next = (!in_end && (hit_reg || found_reg)) ? ST_LEFT : ST_DONE;
                end
            end

            ST_LEFT:
            begin
                emit_need   = multi || (cnt_dec == '0);
                emit_evt.ev = EV_LEFT;
                if (!(emit_need && !can_emit))
                begin
                    emit_go    = emit_need;
                    clr_en     = left_has_reg;
                    count_next = cnt_dec;
                    state_next = ST_DONE;
                end
            end

            ST_TICK:
            begin
                emit_evt.ev    = EV_STAY;
                emit_evt.okind = slot_kind_reg[idx_reg];
                emit_evt.id    = slot_id_reg[idx_reg];
                if (!(slot_stay && !can_emit))
                begin
                    emit_go    = slot_stay;
                    tim_en     = slot_stay;
                    nemit_next = slot_stay ? nemit_reg + 1'b1 : nemit_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                // the held event is the final one of this item
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (evt_ready)
                begin
                    evt_push        = 1'b1;
                    evt_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one event is held back until it is known whether another follows
        if (emit_go)
        begin
            if (pend_valid_reg)
            begin
                evt_push = 1'b1;
            end
            pend_next       = emit_evt;
            pend_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            if (ins_en)
            begin
                slot_valid_reg[free_idx_reg] <= 1'b1;
            end
            if (clr_en)
            begin
                slot_valid_reg[left_idx_reg] <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        left_has_reg  <= left_has_next;
        left_idx_reg  <= left_idx_next;
        hit_reg       <= hit_next;
        axis_reg      <= axis_next;
        ph_reg        <= ph_next;
        fst_reg       <= fst_next;
        fet_reg       <= fet_next;
        val_reg       <= val_next;
        q_reg         <= q_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        step_reg      <= step_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        off_reg       <= off_next;
        nemit_reg     <= nemit_next;
        pend_reg      <= pend_next;
    end

    // table payload
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            slot_kind_reg[free_idx_reg] <= cmd_reg.kind;
            slot_id_reg[free_idx_reg]   <= cmd_reg.id;
            slot_time_reg[free_idx_reg] <= cmd_reg.now_ms;
        end
        if (tim_en)
        begin
            slot_time_reg[idx_reg] <= cmd_reg.now_ms;
        end
    end

endmodule
`default_nettype wire

>>> design/swept_box_zone_occupancy_top.sv
// Top level: register port, front end, command queue, back end, event queue.
// A move's time is set by the table walk and the serial divider (one quotient bit a cycle);
// a leave's by the table walk, and a tick's by the table walk when a stay period is set.
// Items are worked one at a time; two items queue in front. The last result of an item
// is released when the item ends. Output stalls add to these times.
// Reset (rst_n low, asynchronous) empties the table and loads register defaults.
`default_nettype none
module swept_box_zone_occupancy_top #(
    parameter int TABLE_DEPTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // object_kind, object_id, start_x, start_y, start_z, end_x, end_y, end_z,
    // is_jumping, time_now_ms
    input  logic [223:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_object_kind, event_object_id, offset_x, offset_y, offset_z
    output logic [111:0] m_tdata,
    // event_kind
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    import szo_pkg::*;

    cfg_t              cfg_reg;
    logic              wr_en;
    logic              cq_push, cq_ready, cq_valid, cq_pop;
    cmd_t              cq_din, cq_dout;
    logic              eq_push, eq_ready;
    evt_t              eq_din, eq_dout;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{center: '0, ext: '0, mode: MODE_W'(8), period: '0};
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_CENTER_X:     cfg_reg.center[0] <= pwdata[COORD_W-1:0];
                REG_BASE_Y:       cfg_reg.center[1] <= pwdata[COORD_W-1:0];
                REG_CENTER_Z:     cfg_reg.center[2] <= pwdata[COORD_W-1:0];
                REG_HALF_WIDTH_X: cfg_reg.ext[0]    <= pwdata[DIM_W-1:0];
                REG_HEIGHT_Y:     cfg_reg.ext[1]    <= pwdata[DIM_W-1:0];
                REG_HALF_DEPTH_Z: cfg_reg.ext[2]    <= pwdata[DIM_W-1:0];
                REG_MODE_FLAGS:   cfg_reg.mode      <= pwdata[MODE_W-1:0];
                REG_STAY_PERIOD:  cfg_reg.period    <= pwdata[PERIOD_W-1:0];
                default:          cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[4:2])
            REG_CENTER_X:     prdata = 32'(cfg_reg.center[0]);
            REG_BASE_Y:       prdata = 32'(cfg_reg.center[1]);
            REG_CENTER_Z:     prdata = 32'(cfg_reg.center[2]);
            REG_HALF_WIDTH_X: prdata = 32'(cfg_reg.ext[0]);
            REG_HEIGHT_Y:     prdata = 32'(cfg_reg.ext[1]);
            REG_HALF_DEPTH_Z: prdata = 32'(cfg_reg.ext[2]);
            REG_MODE_FLAGS:   prdata = 32'(cfg_reg.mode);
            REG_STAY_PERIOD:  prdata = 32'(cfg_reg.period);
            default:          prdata = '0;
        endcase
    end

    szo_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_ready  (cq_ready),
        .q_push   (cq_push),
        .q_data   (cq_din)
    );

    szo_queue #(.WIDTH($bits(cmd_t))) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cq_push),
        .din       (cq_din),
        .in_ready  (cq_ready),
        .pop       (cq_pop),
        .dout      (cq_dout),
        .out_valid (cq_valid)
    );

    szo_back #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cq_valid),
        .cmd_data  (cq_dout),
        .cmd_pop   (cq_pop),
        .evt_ready (eq_ready),
        .evt_push  (eq_push),
        .evt_data  (eq_din)
    );

    szo_queue #(.WIDTH($bits(evt_t))) u_evt_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (eq_push),
        .din       (eq_din),
        .in_ready  (eq_ready),
        .pop       (m_tready),
        .dout      (eq_dout),
        .out_valid (m_tvalid)
    );

    // result packing
    assign m_tdata = {3'b000, eq_dout.off[2], eq_dout.off[1], eq_dout.off[0],
                      eq_dout.id, eq_dout.okind};
    assign m_tuser = eq_dout.ev;
    assign m_tlast = eq_dout.last;

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking bench for the swept box zone occupancy block: directed and random moves, leaves and ticks.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import szo_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    swept_box_zone_occupancy_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    localparam int  DEPTH     = 16;
    localparam int  FRAC      = 16;
    localparam longint UNITY  = 64'sd1 << FRAC;
    localparam longint C_MIN  = -(64'sd1 <<< 23);
    localparam longint C_MAX  = (64'sd1 <<< 23) - 1;

    // zone registers as last written
    logic [COORD_W-1:0]  zone_center [3];
    logic [DIM_W-1:0]    zone_ext [3];
    logic [MODE_W-1:0]   zone_mode;
    logic [PERIOD_W-1:0] zone_period;

    // occupancy table copy
    bit                 occ_valid [DEPTH];
    logic [KIND_W-1:0]  occ_kind [DEPTH];
    logic [ID_W-1:0]    occ_id [DEPTH];
    logic [TIME_W-1:0]  occ_time [DEPTH];
    int                 occ_count;

    cmd_t   pending_moves[$];
    evt_t   expected_events[$];
    int     errors;
    int     s_gap;
    int     m_gap;
    bit     s_took;
    bit     calm;
    logic [TIME_W-1:0] clock_ms;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint sgn24(logic [COORD_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic int find_occupant(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (occ_valid[i] && occ_kind[i] == kind && occ_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void add_event(ref evt_t evs[$], input evt_kind_t ev,
                                      input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                      input longint dx, input longint dy, input longint dz);
        evt_t r;
        if (evs.size() >= MAX_RESULTS)
            return;
        r.ev = ev;
        r.okind = kind;
        r.id = id;
        r.off[0] = OFF_W'(dx);
        r.off[1] = OFF_W'(dy);
        r.off[2] = OFF_W'(dz);
        r.last = 1'b0;
        evs.push_back(r);
    endfunction

    // removes the object if recorded, then reports it in multi mode or when no others remain
    function automatic void leave_zone(ref evt_t evs[$], input logic [KIND_W-1:0] kind,
                                       input logic [ID_W-1:0] id);
        int k;
        k = find_occupant(kind, id);
        if (k >= 0)
        begin
            occ_valid[k] = 1'b0;
            if (occ_count > 0)
                occ_count--;
        end
        if (zone_mode[MODE_MULTI] || occ_count == 0)
            add_event(evs, EV_LEFT, kind, id, 0, 0, 0);
    endfunction

    function automatic longint slab_fraction(longint num, longint den);
        longint q;
        q = (num <<< FRAC) / den;
        return (q > UNITY) ? UNITY : q;
    endfunction

    function automatic longint interpolate(longint s, longint e, longint f);
        longint d;
        longint p;
        d = e - s;
        p = (((d < 0) ? -d : d) * f) >>> FRAC;
        return (d < 0) ? s - p : s + p;
    endfunction

    // slab test of segment s..e against box lo..hi, earliest entry point in hit
    function automatic bit slab_sweep(input longint s[3], input longint e[3],
                                      input longint lo[3], input longint hi[3],
                                      output longint hit[3]);
        longint f_in;
        longint f_out;
        longint st;
        longint et;
        f_in = 0;
        f_out = UNITY;
        for (int i = 0; i < 3; i++)
        begin
            if (s[i] < e[i])
            begin
                if (s[i] > hi[i] || e[i] < lo[i])
                    return 1'b0;
                st = (s[i] < lo[i]) ? slab_fraction(lo[i] - s[i], e[i] - s[i]) : 0;
                et = (e[i] > hi[i]) ? slab_fraction(hi[i] - s[i], e[i] - s[i]) : UNITY;
            end
            else
            begin
                if (e[i] > hi[i] || s[i] < lo[i])
                    return 1'b0;
                st = (s[i] > hi[i]) ? slab_fraction(s[i] - hi[i], s[i] - e[i]) : 0;
                et = (e[i] < lo[i]) ? slab_fraction(s[i] - lo[i], s[i] - e[i]) : UNITY;
            end
            if (st > f_in)
                f_in = st;
            if (et < f_out)
                f_out = et;
            if (f_out < f_in)
                return 1'b0;
        end
        for (int i = 0; i < 3; i++)
            hit[i] = interpolate(s[i], e[i], f_in);
        return 1'b1;
    endfunction

    // zone bounds on one axis
    function automatic longint zone_lo(int a);
        return (a == 1) ? sgn24(zone_center[a])
                        : sgn24(zone_center[a]) - longint'(zone_ext[a]);
    endfunction

    function automatic longint zone_hi(int a);
        return sgn24(zone_center[a]) + longint'(zone_ext[a]);
    endfunction

    // works out the events of one accepted item and updates the table copy
    task automatic predict_events(input cmd_t it);
        evt_t   evs[$];
        longint s[3];
        longint e[3];
        longint lo[3];
        longint hi[3];
        longint c[3];
        longint hit[3];
        bit     was_in;
        bit     in_end;
        int     free_k;
        if (it.op == OP_MOVE)
        begin
            if (!((it.kind == KIND_NPC && !zone_mode[MODE_NPC]) ||
                  (it.kind == KIND_PLAYER && !zone_mode[MODE_PLAYER]) ||
                  (it.kind == KIND_MOVER && !zone_mode[MODE_MOVER])))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s[i] = sgn24(it.seg_start[i]);
                    e[i] = sgn24(it.seg_end[i]);
                    c[i] = sgn24(zone_center[i]);
                    lo[i] = zone_lo(i);
                    hi[i] = zone_hi(i);
                end
                was_in = find_occupant(it.kind, it.id) >= 0;
                if ((zone_mode[MODE_JUMP] || !it.jumping) && slab_sweep(s, e, lo, hi, hit))
                begin
                    if (!was_in)
                    begin
                        free_k = -1;
                        for (int i = DEPTH - 1; i >= 0; i--)
                            if (!occ_valid[i])
                                free_k = i;
                        if (free_k < 0)
                            add_event(evs, EV_FULL, it.kind, it.id,
                                      hit[0] - c[0], hit[1] - c[1], hit[2] - c[2]);
                        else
                        begin
                            occ_valid[free_k] = 1'b1;
                            occ_kind[free_k] = it.kind;
                            occ_id[free_k] = it.id;
                            occ_time[free_k] = it.now_ms;
                            occ_count++;
                            if (zone_mode[MODE_MULTI] || occ_count == 1)
                                add_event(evs, EV_ENTERED, it.kind, it.id,
                                          hit[0] - c[0], hit[1] - c[1], hit[2] - c[2]);
                        end
                    end
                    was_in = 1'b1;
                end
                // box is half-open at its upper faces
                in_end = 1'b1;
                for (int i = 0; i < 3; i++)
                    if (!(e[i] >= lo[i] && e[i] < hi[i]))
                        in_end = 1'b0;
                if (!in_end && was_in)
                    leave_zone(evs, it.kind, it.id);
            end
        end
        else if (it.op == OP_LEAVE)
        begin
            if (find_occupant(it.kind, it.id) >= 0)
                leave_zone(evs, it.kind, it.id);
        end
        else if (it.op == OP_TICK && zone_period != 0)
        begin
            for (int i = 0; i < DEPTH && evs.size() < MAX_RESULTS; i++)
                if (occ_valid[i] && it.now_ms >= occ_time[i] &&
                    it.now_ms - occ_time[i] >= TIME_W'(zone_period))
                begin
                    occ_time[i] = it.now_ms;
                    add_event(evs, EV_STAY, occ_kind[i], occ_id[i], 0, 0, 0);
                end
        end
        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i])
            expected_events.push_back(evs[i]);
    endtask

    function automatic logic [223:0] pack_move(cmd_t it);
        return {5'b0, it.now_ms, it.jumping, it.seg_end[2], it.seg_end[1], it.seg_end[0],
                it.seg_start[2], it.seg_start[1], it.seg_start[0], it.id, it.kind};
    endfunction

    // sample accepted transfers and check results
    always @(posedge clk)
    begin
        evt_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_events(pending_moves.pop_front());
                s_took = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected result: event_kind %0d id %0h", m_tuser, m_tdata[33:2]);
                    errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tuser != want.ev)
                    begin
                        $error("event_kind: expected %0d, got %0d", want.ev, m_tuser);
                        errors++;
                    end
                    if (m_tdata[1:0] != want.okind)
                    begin
                        $error("event_object_kind: expected %0d, got %0d", want.okind,
                               m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[33:2] != want.id)
                    begin
                        $error("event_object_id: expected %0h, got %0h", want.id, m_tdata[33:2]);
                        errors++;
                    end
                    if (m_tdata[58:34] != want.off[0])
                    begin
                        $error("offset_x: expected %0h, got %0h", want.off[0], m_tdata[58:34]);
                        errors++;
                    end
                    if (m_tdata[83:59] != want.off[1])
                    begin
                        $error("offset_y: expected %0h, got %0h", want.off[1], m_tdata[83:59]);
                        errors++;
                    end
                    if (m_tdata[108:84] != want.off[2])
                    begin
                        $error("offset_z: expected %0h, got %0h", want.off[2], m_tdata[108:84]);
                        errors++;
                    end
                    if (m_tlast != want.last)
                    begin
                        $error("last_event: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // item driver and result ready, both with random idle bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_took)
            begin
                s_took = 1'b0;
                if (s_gap > 0)
                begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_moves.size() > 0 && !calm && $urandom_range(0, 9) == 0)
                begin
                    s_gap = $urandom_range(1, 17) - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_moves.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pack_move(pending_moves[0]);
                    s_tuser <= pending_moves[0].op;
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (m_gap > 0)
            begin
                m_gap--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_gap = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_zone(input int cx, input int by, input int cz, input int hx,
                            input int hy, input int hz, input int mode, input int period);
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_BASE_Y, by);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_HALF_WIDTH_X, hx);
        reg_write(REG_HEIGHT_Y, hy);
        reg_write(REG_HALF_DEPTH_Z, hz);
        reg_write(REG_MODE_FLAGS, mode);
        reg_write(REG_STAY_PERIOD, period);
        zone_center[0] = COORD_W'(cx);
        zone_center[1] = COORD_W'(by);
        zone_center[2] = COORD_W'(cz);
        zone_ext[0] = DIM_W'(hx);
        zone_ext[1] = DIM_W'(hy);
        zone_ext[2] = DIM_W'(hz);
        zone_mode = MODE_W'(mode);
        zone_period = PERIOD_W'(period);
    endtask

    // all results in, then room for the queued and running items that produce none
    task automatic wait_idle();
        while (pending_moves.size() != 0 || expected_events.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    function automatic cmd_t make_item(op_t op, int kind, logic [ID_W-1:0] id,
                                       int sx, int sy, int sz, int ex, int ey, int ez,
                                       bit jump, logic [TIME_W-1:0] now);
        cmd_t it;
        it.op = op;
        it.kind = KIND_W'(kind);
        it.id = id;
        it.seg_start[0] = COORD_W'(sx);
        it.seg_start[1] = COORD_W'(sy);
        it.seg_start[2] = COORD_W'(sz);
        it.seg_end[0] = COORD_W'(ex);
        it.seg_end[1] = COORD_W'(ey);
        it.seg_end[2] = COORD_W'(ez);
        it.jumping = jump;
        it.now_ms = now;
        return it;
    endfunction

    // 0 inside, 1 below, 2 above, else anywhere
    function automatic logic [COORD_W-1:0] pick_coord(int a, int how);
        longint lo;
        longint hi;
        longint v;
        lo = zone_lo(a);
        hi = zone_hi(a);
        case (how)
            0: v = lo + longint'($urandom_range(0, 32'(hi - lo)));
            1: v = lo - longint'($urandom_range(1, 4096));
            2: v = hi + longint'($urandom_range(0, 4096));
            default: v = longint'($signed(24'($urandom)));
        endcase
        if (v < C_MIN)
            v = C_MIN;
        if (v > C_MAX)
            v = C_MAX;
        return COORD_W'(v);
    endfunction

    function automatic cmd_t random_item();
        cmd_t it;
        int   r;
        int   smode;
        int   emode;
        r = $urandom_range(0, 99);
        it.op = (r < 60) ? OP_MOVE : (r < 75) ? OP_LEAVE : (r < 95) ? OP_TICK : OP_NONE;
        it.kind = KIND_W'($urandom_range(0, 3));
        it.id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(1, 22));
        smode = $urandom_range(0, 2);
        emode = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++)
        begin
            it.seg_start[a] = pick_coord(a, smode == 0 ? 0 : smode == 1 ?
                                         $urandom_range(0, 3) : 3);
            it.seg_end[a] = pick_coord(a, emode == 0 ? 0 : emode == 1 ?
                                       $urandom_range(0, 3) : 3);
        end
        it.jumping = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 39) == 0)
            clock_ms = {8'($urandom), 32'($urandom)};
        else
            clock_ms += TIME_W'($urandom_range(0, 60));
        it.now_ms = ($urandom_range(0, 15) == 0) ? clock_ms - TIME_W'($urandom_range(1, 100))
                                                 : clock_ms;
        return it;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) pending_moves.push_back(random_item());
        wait_idle();
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        s_gap = 0;
        m_gap = 0;
        s_took = 1'b0;
        calm = 1'b0;
        clock_ms = 1000;
        occ_count = 0;
        for (int i = 0; i < DEPTH; i++)
            occ_valid[i] = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            zone_center[a] = '0;
            zone_ext[a] = '0;
        end
        zone_mode = MODE_W'(8);
        zone_period = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: point box at origin, only kind 0 checked
        pending_moves.push_back(make_item(OP_MOVE, 0, 1, -1, -1, -1, 1, 1, 1, 0, 10));
        pending_moves.push_back(make_item(OP_MOVE, 1, 1, -1, -1, -1, 1, 1, 1, 0, 11));
        pending_moves.push_back(make_item(OP_NONE, 0, 1, 0, 0, 0, 0, 0, 0, 0, 12));
        pending_moves.push_back(make_item(OP_TICK, 0, 1, 0, 0, 0, 0, 0, 0, 0, 13));
        pending_moves.push_back(make_item(OP_LEAVE, 0, 1, 0, 0, 0, 0, 0, 0, 0, 14));
        wait_idle();

        // moderate box, everything on
        set_zone(4096, -2048, 8192, 2048, 4096, 1536, 31, 40);
        pending_moves.push_back(make_item(OP_MOVE, 0, 7, 0, 0, 8192, 4096, 0, 8192, 0, 100));
        pending_moves.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 120));
        pending_moves.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 140));
        pending_moves.push_back(make_item(OP_MOVE, 1, 7, -8388608, -8388608, -8388608,
                                          8388607, 8388607, 8388607, 1, 150));
        pending_moves.push_back(make_item(OP_MOVE, 0, 7, 4096, 0, 8192, 4100, 10, 8000, 0, 160));
        pending_moves.push_back(make_item(OP_MOVE, 0, 7, 4100, 10, 8000, 8000, 0, 8192, 0, 170));
        pending_moves.push_back(make_item(OP_MOVE, 2, 32'hFFFF_FFFF, 0, 0, 8192,
                                          9000, 0, 8192, 0, 180));
        pending_moves.push_back(make_item(OP_MOVE, 3, 0, 4096, 6000, 8192, 4096, 0, 8192, 0, 190));
        pending_moves.push_back(make_item(OP_LEAVE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 200));
        pending_moves.push_back(make_item(OP_MOVE, 0, 9, 4096, 0, 8192, 6144, 2048, 9728, 0, 210));
        pending_moves.push_back(make_item(OP_NONE, 2, 3, 0, 0, 0, 0, 0, 0, 1, 220));
        pending_moves.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10));
        wait_idle();
        clock_ms = 300;
        random_phase(60);

        // extreme box covering nearly all space, longest period
        set_zone(-8388608, 8388607, 0, 8388607, 8388607, 8388607, 24, 16777215);
        random_phase(50);

        // only kind 0 checked, jumps skip the sweep
        set_zone(-3000, 500, -7000, 1500, 2500, 3500, 0, 1);
        random_phase(50);

        // no multi-activation
        set_zone(8388607, -8388608, 100, 0, 6000, 4000, 15, 100);
        random_phase(40);
        set_zone(200, 0, -200, 3000, 3000, 3000, 15, 30);
        random_phase(50);

        // final stretch without idling
        set_zone(0, -1000, 0, 5000, 5000, 5000, 23, 25);
        calm = 1'b1;
        random_phase(50);

        if (expected_events.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_events.size());
            errors++;
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
